@@ design/chp_pkg.sv @@
// Shared types, colors and per-standard frame geometry for the crosshatch pattern.
package chp_pkg;

    // Field widths
    localparam int unsigned X_W   = 10;
    localparam int unsigned Y_W   = 9;
    localparam int unsigned RGB_W = 24;
    localparam int unsigned STD_W = 2;

    // Video standard codes; the unused code falls back to NTSC
    typedef enum logic [STD_W-1:0] {
        STD_NTSC = 2'd0,
        STD_PAL  = 2'd1,
        STD_480I = 2'd2
    } t_std;

    localparam t_std STD_RESET = STD_NTSC;

    // Colors
    localparam logic [RGB_W-1:0] COL_WHITE = 24'hFFFFFF;
    localparam logic [RGB_W-1:0] COL_GREY  = 24'hA0A0A0;
    localparam logic [RGB_W-1:0] COL_DIM   = 24'h404040;
    localparam logic [RGB_W-1:0] COL_BLACK = 24'h000000;

    // Frame sizes
    localparam int WIDTH_SD    = 352;
    localparam int WIDTH_480I  = 720;
    localparam int HEIGHT_NTSC = 240;
    localparam int HEIGHT_PAL  = 288;
    localparam int HEIGHT_480I = 480;

    // Center cross half spans
    localparam int CROSS_HALF_X = 16;
    localparam int CROSS_HALF_Y = 12;

    // Crosshatch divisions
    localparam int HATCH_COLS = 16;
    localparam int HATCH_ROWS = 12;

    // Safe box inset divisor
    localparam int SAFE_DIV = 20;

    // Precomputed frame geometry for one standard
    typedef struct packed {
        logic [X_W-1:0] width;
        logic [X_W-1:0] x_last;
        logic [X_W-1:0] cx;
        logic [X_W-1:0] cx_lo;
        logic [X_W-1:0] cx_hi;
        logic [X_W-1:0] ix;
        logic [X_W-1:0] ix_far;
        logic [Y_W-1:0] height;
        logic [Y_W-1:0] y_last;
        logic [Y_W-1:0] cy;
        logic [Y_W-1:0] cy_lo;
        logic [Y_W-1:0] cy_hi;
        logic [Y_W-1:0] iy;
        logic [Y_W-1:0] iy_far;
    } t_geom;

    // Horizontal geometry; the SD values are shared by NTSC and PAL
    localparam int SD_CX   = WIDTH_SD / 2;
    localparam int SD_IX   = WIDTH_SD / SAFE_DIV;
    localparam int HD_CX   = WIDTH_480I / 2;
    localparam int HD_IX   = WIDTH_480I / SAFE_DIV;
    // Vertical geometry
    localparam int NTSC_CY = HEIGHT_NTSC / 2;
    localparam int NTSC_IY = HEIGHT_NTSC / SAFE_DIV;
    localparam int PAL_CY  = HEIGHT_PAL / 2;
    localparam int PAL_IY  = HEIGHT_PAL / SAFE_DIV;
    localparam int HD_CY   = HEIGHT_480I / 2;
    localparam int HD_IY   = HEIGHT_480I / SAFE_DIV;

    localparam t_geom GEOM_NTSC = '{
        width:  X_W'(WIDTH_SD),
        x_last: X_W'(WIDTH_SD - 1),
        cx:     X_W'(SD_CX),
        cx_lo:  X_W'(SD_CX - CROSS_HALF_X),
        cx_hi:  X_W'(SD_CX + CROSS_HALF_X),
        ix:     X_W'(SD_IX),
        ix_far: X_W'(WIDTH_SD - 1 - SD_IX),
        height: Y_W'(HEIGHT_NTSC),
        y_last: Y_W'(HEIGHT_NTSC - 1),
        cy:     Y_W'(NTSC_CY),
        cy_lo:  Y_W'(NTSC_CY - CROSS_HALF_Y),
        cy_hi:  Y_W'(NTSC_CY + CROSS_HALF_Y),
        iy:     Y_W'(NTSC_IY),
        iy_far: Y_W'(HEIGHT_NTSC - 1 - NTSC_IY)
    };

    localparam t_geom GEOM_PAL = '{
        width:  X_W'(WIDTH_SD),
        x_last: X_W'(WIDTH_SD - 1),
        cx:     X_W'(SD_CX),
        cx_lo:  X_W'(SD_CX - CROSS_HALF_X),
        cx_hi:  X_W'(SD_CX + CROSS_HALF_X),
        ix:     X_W'(SD_IX),
        ix_far: X_W'(WIDTH_SD - 1 - SD_IX),
        height: Y_W'(HEIGHT_PAL),
        y_last: Y_W'(HEIGHT_PAL - 1),
        cy:     Y_W'(PAL_CY),
        cy_lo:  Y_W'(PAL_CY - CROSS_HALF_Y),
        cy_hi:  Y_W'(PAL_CY + CROSS_HALF_Y),
        iy:     Y_W'(PAL_IY),
        iy_far: Y_W'(HEIGHT_PAL - 1 - PAL_IY)
    };

    localparam t_geom GEOM_480I = '{
        width:  X_W'(WIDTH_480I),
        x_last: X_W'(WIDTH_480I - 1),
        cx:     X_W'(HD_CX),
        cx_lo:  X_W'(HD_CX - CROSS_HALF_X),
        cx_hi:  X_W'(HD_CX + CROSS_HALF_X),
        ix:     X_W'(HD_IX),
        ix_far: X_W'(WIDTH_480I - 1 - HD_IX),
        height: Y_W'(HEIGHT_480I),
        y_last: Y_W'(HEIGHT_480I - 1),
        cy:     Y_W'(HD_CY),
        cy_lo:  Y_W'(HD_CY - CROSS_HALF_Y),
        cy_hi:  Y_W'(HD_CY + CROSS_HALF_Y),
        iy:     Y_W'(HD_IY),
        iy_far: Y_W'(HEIGHT_480I - 1 - HD_IY)
    };

    // Result of one pixel
    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        logic             outside;
    } t_pix;

endpackage

@@ design/chp_pattern.sv @@
// Combinational pattern decode: pixel coordinate and standard to color.
module chp_pattern (
    input  logic [chp_pkg::STD_W-1:0] i_std,
    input  logic [chp_pkg::X_W-1:0]   i_x,
    input  logic [chp_pkg::Y_W-1:0]   i_y,
    output chp_pkg::t_pix             o_pix
);

    chp_pkg::t_geom geom;
    logic           wide;
    logic           outside;
    logic           border, cross_h, cross_v, grey_h, grey_v;
    logic           hatch_sd, hatch_hd, hatch_ntsc, hatch_pal, hatch_480i;
    logic           hatch_x, hatch_y;

    // Geometry select; the unused code maps to NTSC
    always_comb begin
        case (chp_pkg::t_std'(i_std))
            chp_pkg::STD_PAL:  geom = chp_pkg::GEOM_PAL;
            chp_pkg::STD_480I: geom = chp_pkg::GEOM_480I;
            default:           geom = chp_pkg::GEOM_NTSC;
        endcase
    end

    assign wide = (chp_pkg::t_std'(i_std) == chp_pkg::STD_480I);

    // Hatch column hits for both frame widths, all compares against constants
    always_comb begin
        hatch_sd = 1'b0;
        hatch_hd = 1'b0;
        for (int i = 1; i < chp_pkg::HATCH_COLS; i++) begin
            hatch_sd |= (i_x == chp_pkg::X_W'((i * chp_pkg::WIDTH_SD) / chp_pkg::HATCH_COLS));
            hatch_hd |= (i_x == chp_pkg::X_W'((i * chp_pkg::WIDTH_480I) / chp_pkg::HATCH_COLS));
        end
    end

    always_comb begin
        hatch_ntsc = 1'b0;
        hatch_pal  = 1'b0;
        hatch_480i = 1'b0;
        for (int j = 1; j < chp_pkg::HATCH_ROWS; j++) begin
            hatch_ntsc |= (i_y == chp_pkg::Y_W'((j * chp_pkg::HEIGHT_NTSC)
                                                / chp_pkg::HATCH_ROWS));
            hatch_pal  |= (i_y == chp_pkg::Y_W'((j * chp_pkg::HEIGHT_PAL)
                                                / chp_pkg::HATCH_ROWS));
            hatch_480i |= (i_y == chp_pkg::Y_W'((j * chp_pkg::HEIGHT_480I)
                                                / chp_pkg::HATCH_ROWS));
        end
    end

    always_comb begin
        case (chp_pkg::t_std'(i_std))
            chp_pkg::STD_PAL:  hatch_y = hatch_pal;
            chp_pkg::STD_480I: hatch_y = hatch_480i;
            default:           hatch_y = hatch_ntsc;
        endcase
    end

    assign hatch_x = wide ? hatch_hd : hatch_sd;

    // Feature hits
    assign outside = (i_x >= geom.width) || (i_y >= geom.height);
    assign border  = (i_x == '0) || (i_y == '0) || (i_x == geom.x_last) || (i_y == geom.y_last);
    assign cross_h = (i_y == geom.cy) && (i_x >= geom.cx_lo) && (i_x <= geom.cx_hi);
    assign cross_v = (i_x == geom.cx) && (i_y >= geom.cy_lo) && (i_y <= geom.cy_hi);
    assign grey_h  = ((i_y == geom.iy) || (i_y == geom.iy_far))
                     && (i_x >= geom.ix) && (i_x <= geom.ix_far);
    assign grey_v  = ((i_x == geom.ix) || (i_x == geom.ix_far))
                     && (i_y >= geom.iy) && (i_y <= geom.iy_far);

    // Priority: outside, white, grey, dim, black
    always_comb begin
        o_pix.outside = outside;
        if (outside) begin
            o_pix.rgb = chp_pkg::COL_BLACK;
        end else if (border || cross_h || cross_v) begin
            o_pix.rgb = chp_pkg::COL_WHITE;
        end else if (grey_h || grey_v) begin
            o_pix.rgb = chp_pkg::COL_GREY;
        end else if (hatch_x || hatch_y) begin
            o_pix.rgb = chp_pkg::COL_DIM;
        end else begin
            o_pix.rgb = chp_pkg::COL_BLACK;
        end
    end

endmodule

@@ design/crosshatch_test_pattern_pixel.sv @@
// Top level of the crosshatch test pattern pixel generator.
//
//  Channel   Direction  Handshake                  Payload
//  cfg       in         i_cfg_we                   i_cfg_data (video standard)
//  in        in         i_in_valid / o_in_stall    i_pixel_x, i_pixel_y
//  out       out        o_out_valid / i_out_stall  o_pixel_rgb, o_outside_frame
//
// One pixel per clock sustained while the output is not stalled; a result passes through
// the input register, pattern decode and result register.
// Synchronous active-low reset empties both stages and selects NTSC.
// An output stall holds the result register; the input register still takes a beat
// while it is empty, so the input side stalls only when both stages are full.
module crosshatch_test_pattern_pixel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration
    input  logic                        i_cfg_we,
    input  logic [chp_pkg::STD_W-1:0]   i_cfg_data,
    // Input pixel coordinates
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [chp_pkg::X_W-1:0]     i_pixel_x,
    input  logic [chp_pkg::Y_W-1:0]     i_pixel_y,
    // Output pixel color
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [chp_pkg::RGB_W-1:0]   o_pixel_rgb,
    output logic                        o_outside_frame
);

    logic [chp_pkg::STD_W-1:0] r_std;
    logic                      r_s1_valid, n_s1_valid;
    logic [chp_pkg::X_W-1:0]   r_x;
    logic [chp_pkg::Y_W-1:0]   r_y;
    logic                      r_out_valid, n_out_valid;
    chp_pkg::t_pix             r_pix;
    chp_pkg::t_pix             pix;
    logic                      adv_out, adv_in;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std <= chp_pkg::STD_RESET;
        end else if (i_cfg_we) begin
            r_std <= i_cfg_data;
        end
    end

    // Stage enables
    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv_in     = !r_s1_valid || adv_out;
    assign o_in_stall = !adv_in;

    assign n_s1_valid  = adv_in ? i_in_valid : r_s1_valid;
    assign n_out_valid = adv_out ? r_s1_valid : r_out_valid;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_in_valid) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
        end
    end

    // Pattern decode
    chp_pattern u_pattern (
        .i_std (r_std),
        .i_x   (r_x),
        .i_y   (r_y),
        .o_pix (pix)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_pix <= pix;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_rgb     = r_pix.rgb;
    assign o_outside_frame = r_pix.outside;

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Off-frame pixels are black
    a_outside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outside_frame |-> o_pixel_rgb == chp_pkg::COL_BLACK)
        else $error("off-frame pixel not black");

    // Only the four pattern colors ever leave the block
    a_color_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_rgb == chp_pkg::COL_WHITE) || (o_pixel_rgb == chp_pkg::COL_GREY)
                     || (o_pixel_rgb == chp_pkg::COL_DIM) || (o_pixel_rgb == chp_pkg::COL_BLACK))
        else $error("unexpected pixel color");

    // Input side stalls only when both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled without cause");

    // A decoded beat moves into an empty result stage
    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_out_valid |=> o_out_valid)
        else $error("beat lost between stages");

endmodule

@@ tb/sv/crosshatch_test_pattern_pixel_checker.sv @@
// Checker for the crosshatch pattern pixel generator: predicts each pixel color and compares.
`timescale 1ns / 100ps

module crosshatch_test_pattern_pixel_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [chp_pkg::STD_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [chp_pkg::X_W-1:0]     i_pixel_x,
    input  logic [chp_pkg::Y_W-1:0]     i_pixel_y,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [chp_pkg::RGB_W-1:0]   i_pixel_rgb,
    input  logic                        i_outside_frame,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int MAX_REPORTS = 10;

    // One predicted pixel, with its coordinate kept for reporting
    typedef struct {
        logic [chp_pkg::X_W-1:0]   x;
        logic [chp_pkg::Y_W-1:0]   y;
        logic [chp_pkg::STD_W-1:0] video_std;
        chp_pkg::t_pix             pix;
    } t_pixel_expect;

    t_pixel_expect             pixel_queue[$];
    t_pixel_expect             want;
    logic [chp_pkg::STD_W-1:0] video_std = chp_pkg::STD_RESET;
    int                        fail_n    = 0;

    // Color of one pixel of the alignment pattern under a given standard
    function automatic chp_pkg::t_pix pattern_pixel(logic [chp_pkg::X_W-1:0] px,
                                                    logic [chp_pkg::Y_W-1:0] py,
                                                    logic [chp_pkg::STD_W-1:0] vstd);
        int            w, h, cx, cy, ix, iy, xi, yi, k, hx, hy;
        bit            on_hatch;
        chp_pkg::t_pix r;
        case (vstd)
            chp_pkg::STD_480I: begin
                w = chp_pkg::WIDTH_480I;
                h = chp_pkg::HEIGHT_480I;
            end
            chp_pkg::STD_PAL: begin
                w = chp_pkg::WIDTH_SD;
                h = chp_pkg::HEIGHT_PAL;
            end
            default: begin
                // the unused code falls back to NTSC
                w = chp_pkg::WIDTH_SD;
                h = chp_pkg::HEIGHT_NTSC;
            end
        endcase
        xi = int'(px);
        yi = int'(py);
        cx = w / 2;
        cy = h / 2;
        ix = w / chp_pkg::SAFE_DIV;
        iy = h / chp_pkg::SAFE_DIV;
        hx = chp_pkg::CROSS_HALF_X;
        hy = chp_pkg::CROSS_HALF_Y;
        r.outside = 1'b0;
        r.rgb     = chp_pkg::COL_BLACK;
        if (xi >= w || yi >= h) begin
            r.outside = 1'b1;
        end else if (xi == 0 || yi == 0 || xi == w - 1 || yi == h - 1) begin
            r.rgb = chp_pkg::COL_WHITE;
        end else if (yi == cy && xi >= cx - hx && xi <= cx + hx) begin
            r.rgb = chp_pkg::COL_WHITE;
        end else if (xi == cx && yi >= cy - hy && yi <= cy + hy) begin
            r.rgb = chp_pkg::COL_WHITE;
        end else if ((yi == iy || yi == h - 1 - iy) && xi >= ix && xi <= w - 1 - ix) begin
            r.rgb = chp_pkg::COL_GREY;
        end else if ((xi == ix || xi == w - 1 - ix) && yi >= iy && yi <= h - 1 - iy) begin
            r.rgb = chp_pkg::COL_GREY;
        end else begin
            on_hatch = 1'b0;
            for (k = 1; k < chp_pkg::HATCH_COLS; k++)
                if (xi == k * w / chp_pkg::HATCH_COLS) on_hatch = 1'b1;
            for (k = 1; k < chp_pkg::HATCH_ROWS; k++)
                if (yi == k * h / chp_pkg::HATCH_ROWS) on_hatch = 1'b1;
            if (on_hatch) r.rgb = chp_pkg::COL_DIM;
        end
        return r;
    endfunction

    // Watch all three ports at each edge; results are checked before new inputs are queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            video_std = chp_pkg::STD_RESET;
            pixel_queue.delete();
        end else begin
            // result beat against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (pixel_queue.size() == 0) begin
                    fail_n++;
                    if (fail_n <= MAX_REPORTS)
                        $display("%0t: result beat with nothing pending: rgb=%06h outside=%0b",
                                 $time, i_pixel_rgb, i_outside_frame);
                end else begin
                    want = pixel_queue.pop_front();
                    if (i_pixel_rgb !== want.pix.rgb || i_outside_frame !== want.pix.outside)
                    begin
                        fail_n++;
                        if (fail_n <= MAX_REPORTS)
                            $display("%0t: std=%0d x=%0d y=%0d: expected rgb=%06h ",
                                     $time, want.video_std, want.x, want.y, want.pix.rgb,
                                     "outside=%0b, got rgb=%06h outside=%0b",
                                     want.pix.outside, i_pixel_rgb, i_outside_frame);
                    end
                end
            end
            // input beat: predict with the standard in force before this edge
            if (i_in_valid && !i_in_stall) begin
                want.x         = i_pixel_x;
                want.y         = i_pixel_y;
                want.video_std = video_std;
                want.pix       = pattern_pixel(i_pixel_x, i_pixel_y, video_std);
                pixel_queue.push_back(want);
            end
            if (i_cfg_we) video_std = i_cfg_data;
        end
        o_fail_count <= fail_n;
        o_pending    <= pixel_queue.size();
    end

endmodule

@@ tb/sv/crosshatch_test_pattern_pixel_tb.sv @@
// Testbench top for the crosshatch pattern pixel generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module crosshatch_test_pattern_pixel_tb;

    localparam logic [chp_pkg::STD_W-1:0] STD_UNUSED  = 2'd3;
    localparam int                        PHASES      = 6;
    localparam int                        PHASE_BEATS = 265;
    localparam int                        IDLE_PCT    = 21;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_cfg_we        = 1'b0;
    logic [chp_pkg::STD_W-1:0]   i_cfg_data      = chp_pkg::STD_RESET;
    logic                        i_in_valid      = 1'b0;
    logic [chp_pkg::X_W-1:0]     i_pixel_x       = '0;
    logic [chp_pkg::Y_W-1:0]     i_pixel_y       = '0;
    logic                        i_out_stall     = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [chp_pkg::RGB_W-1:0]   o_pixel_rgb;
    logic                        o_outside_frame;
    int                          fail_count;
    int                          pending;

    // no idling on either side while set
    bit                          steady  = 1'b0;
    logic [chp_pkg::STD_W-1:0]   cur_std = chp_pkg::STD_RESET;

    always #1 i_clk = ~i_clk;

    crosshatch_test_pattern_pixel u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_rgb     (o_pixel_rgb),
        .o_outside_frame (o_outside_frame)
    );

    crosshatch_test_pattern_pixel_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_pixel_rgb     (o_pixel_rgb),
        .i_outside_frame (o_outside_frame),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver stalls at random outside the steady stretch
    always @(posedge i_clk) begin
        i_out_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    function automatic chp_pkg::t_geom frame_geom(logic [chp_pkg::STD_W-1:0] s);
        case (s)
            chp_pkg::STD_PAL:  return chp_pkg::GEOM_PAL;
            chp_pkg::STD_480I: return chp_pkg::GEOM_480I;
            default:           return chp_pkg::GEOM_NTSC;
        endcase
    endfunction

    // Column on some pattern feature, sometimes nudged by one
    function automatic logic [chp_pkg::X_W-1:0] feature_x(chp_pkg::t_geom g);
        int v;
        case ($urandom_range(8))
            0:       v = 0;
            1:       v = int'(g.x_last);
            2:       v = int'(g.width);
            3:       v = int'(g.cx);
            4:       v = int'(g.cx_lo);
            5:       v = int'(g.cx_hi);
            6:       v = int'(g.ix);
            7:       v = int'(g.ix_far);
            default: v = int'($urandom_range(1, chp_pkg::HATCH_COLS - 1)) * int'(g.width)
                         / chp_pkg::HATCH_COLS;
        endcase
        if ($urandom_range(2) == 0) v = v + int'($urandom_range(2)) - 1;
        return chp_pkg::X_W'(v);
    endfunction

    // Row on some pattern feature, sometimes nudged by one
    function automatic logic [chp_pkg::Y_W-1:0] feature_y(chp_pkg::t_geom g);
        int v;
        case ($urandom_range(8))
            0:       v = 0;
            1:       v = int'(g.y_last);
            2:       v = int'(g.height);
            3:       v = int'(g.cy);
            4:       v = int'(g.cy_lo);
            5:       v = int'(g.cy_hi);
            6:       v = int'(g.iy);
            7:       v = int'(g.iy_far);
            default: v = int'($urandom_range(1, chp_pkg::HATCH_ROWS - 1)) * int'(g.height)
                         / chp_pkg::HATCH_ROWS;
        endcase
        if ($urandom_range(2) == 0) v = v + int'($urandom_range(2)) - 1;
        return chp_pkg::Y_W'(v);
    endfunction

    // Random coordinate, weighted toward lines, the cross and the frame edges
    task automatic pick_pixel(input chp_pkg::t_geom g, output logic [chp_pkg::X_W-1:0] x,
                              output logic [chp_pkg::Y_W-1:0] y);
        int mode;
        mode = $urandom_range(99);
        if (mode < 25) begin
            x = chp_pkg::X_W'($urandom_range(1023));
            y = chp_pkg::Y_W'($urandom_range(511));
        end else if (mode < 45) begin
            x = chp_pkg::X_W'($urandom_range(int'(g.width) - 1));
            y = chp_pkg::Y_W'($urandom_range(int'(g.height) - 1));
        end else if (mode < 60) begin
            // around the center cross and just past its ends
            if ($urandom_range(1)) begin
                x = chp_pkg::X_W'(int'(g.cx) - chp_pkg::CROSS_HALF_X - 2
                                  + int'($urandom_range(2 * chp_pkg::CROSS_HALF_X + 4)));
                y = g.cy;
            end else begin
                x = g.cx;
                y = chp_pkg::Y_W'(int'(g.cy) - chp_pkg::CROSS_HALF_Y - 2
                                  + int'($urandom_range(2 * chp_pkg::CROSS_HALF_Y + 4)));
            end
        end else begin
            case ($urandom_range(2))
                0: begin
                    x = feature_x(g);
                    y = feature_y(g);
                end
                1: begin
                    x = feature_x(g);
                    y = chp_pkg::Y_W'($urandom_range(int'(g.height) - 1));
                end
                default: begin
                    x = chp_pkg::X_W'($urandom_range(int'(g.width) - 1));
                    y = feature_y(g);
                end
            endcase
        end
    endtask

    // Offer one beat after a random gap and hold it until taken
    task automatic send_pixel(input logic [chp_pkg::X_W-1:0] x,
                              input logic [chp_pkg::Y_W-1:0] y);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted pixel has come out
    task automatic drain_results;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_standard(input logic [chp_pkg::STD_W-1:0] s);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_std    = s;
    endtask

    // Stimulus
    initial begin
        chp_pkg::t_geom            g;
        logic [chp_pkg::STD_W-1:0] std_plan [PHASES];
        logic [chp_pkg::X_W-1:0]   x;
        logic [chp_pkg::Y_W-1:0]   y;
        int                        p, n;

        std_plan = '{chp_pkg::STD_PAL, chp_pkg::STD_480I, STD_UNUSED, chp_pkg::STD_NTSC,
                     chp_pkg::STD_480I, chp_pkg::STD_PAL};
        std_plan[PHASES-1] = chp_pkg::STD_W'($urandom_range(3));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels under the reset standard
        g = chp_pkg::GEOM_NTSC;
        send_pixel(chp_pkg::X_W'(0), chp_pkg::Y_W'(0));
        send_pixel(g.x_last, g.y_last);
        send_pixel(g.x_last, chp_pkg::Y_W'(0));
        send_pixel(g.width, chp_pkg::Y_W'(100));
        send_pixel(chp_pkg::X_W'(100), g.height);
        send_pixel(chp_pkg::X_W'(1023), chp_pkg::Y_W'(511));
        send_pixel(chp_pkg::X_W'(0), chp_pkg::Y_W'(511));
        send_pixel(chp_pkg::X_W'(1023), chp_pkg::Y_W'(0));
        send_pixel(g.cx, g.cy);
        send_pixel(g.cx_lo, g.cy);
        send_pixel(g.cx_hi, g.cy);
        send_pixel(g.cx_lo - 1'b1, g.cy);
        send_pixel(g.cx, g.cy_lo);
        send_pixel(g.cx, g.cy_hi);
        send_pixel(g.cx, g.cy_hi + 1'b1);
        send_pixel(g.ix, g.iy);
        send_pixel(g.ix_far, g.iy_far);
        send_pixel(g.ix, chp_pkg::Y_W'(100));
        send_pixel(chp_pkg::X_W'(200), g.iy);
        send_pixel(g.ix - 1'b1, chp_pkg::Y_W'(100));
        send_pixel(chp_pkg::X_W'(int'(g.width) / chp_pkg::HATCH_COLS), chp_pkg::Y_W'(5));
        send_pixel(chp_pkg::X_W'(5), chp_pkg::Y_W'(int'(g.height) / chp_pkg::HATCH_ROWS));
        send_pixel(chp_pkg::X_W'(5), chp_pkg::Y_W'(5));

        // Random phases, one video standard each
        for (p = 0; p < PHASES; p++) begin
            write_standard(std_plan[p]);
            g = frame_geom(cur_std);
            for (n = 0; n < PHASE_BEATS; n++) begin
                steady = (p == 1 && n < 200);
                if (p == 3 && n == 130) drain_results();
                pick_pixel(g, x, y);
                send_pixel(x, y);
            end
            steady = 1'b0;
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** crosshatch_test_pattern_pixel: PASSED **");
        else
            $display("** crosshatch_test_pattern_pixel: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("** crosshatch_test_pattern_pixel: FAILED **");
        $finish;
    end

endmodule
